[hdl/gps_pkg.sv]
// ----------------------------------------------------------------------------
// gps_pkg
// shared constants, codes and the sequencer state type of the ga parent
// selection block
// ----------------------------------------------------------------------------
package gps_pkg;

  // default sizing
  localparam int unsigned PopMaxDef      = 64;
  localparam int unsigned FitnessBitsDef = 32;

  // fixed field widths
  localparam int unsigned TotalBits = 38;
  localparam int unsigned IndexBits = 6;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned DrawBits  = 32;
  localparam int unsigned PopBits   = 7;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSelectionMode  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegPopulationSize = 1'd1;

  // command codes
  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSelect = 1'b1;

  // selection modes
  localparam logic ModeTournament = 1'b0;
  localparam logic ModeRoulette   = 1'b1;

  typedef enum logic [7:0] {
    StClear   = 8'b0000_0001,
    StIdle    = 8'b0000_0010,
    StLoadUpd = 8'b0000_0100,
    StTnB     = 8'b0000_1000,
    StTnCmp   = 8'b0001_0000,
    StRwMul   = 8'b0010_0000,
    StRwAdd   = 8'b0100_0000,
    StRwWalk  = 8'b1000_0000
  } gps_state_e;

endpackage

[hdl/ga_parent_selection_top.sv]
// ----------------------------------------------------------------------------
// ga_parent_selection_top
// genetic-algorithm parent selection over a stored fitness table:
// tournament of two picks or roulette wheel by prefix-sum walk
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  command  | start / busy         | func_i, slot_i, fitness_value_i,
//           |                      | first_pick_i, second_pick_i, roulette_draw_i
//  result   | done_o (one cycle)   | selected_index_o, found_o
//  config   | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
//  a word is taken at a rising edge with start high and busy low
//  after reset a clearing pass zeroes the fitness memory, one slot a cycle,
//  with busy high until it ends; config writes are taken meanwhile
//  load: busy in StLoadUpd, which writes the slot and fixes the total from the old value;
//  a load to a slot at or beyond POP_MAX is dropped at once, no result
//  tournament: StTnB reads the second pick, then StTnCmp sets the result behind done_o
//  roulette: StRwMul and StRwAdd form the 38x32 scaling product (split into a 32x32
//  and a 32x6 multiply), then one fitness slot a cycle on the single memory
//  read port until the walk hits or reaches the last slot; a zero total answers
//  on the next cycle; the receiver cannot stall and results never back up
//
module ga_parent_selection_top #(
  parameter int unsigned POP_MAX      = gps_pkg::PopMaxDef,
  parameter int unsigned FITNESS_BITS = gps_pkg::FitnessBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic [gps_pkg::IndexBits-1:0]   slot_i,
  input  logic [gps_pkg::ValueBits-1:0]   fitness_value_i,
  input  logic [gps_pkg::IndexBits-1:0]   first_pick_i,
  input  logic [gps_pkg::IndexBits-1:0]   second_pick_i,
  input  logic [gps_pkg::DrawBits-1:0]    roulette_draw_i,
  // result
  output logic                            done_o,
  output logic [gps_pkg::IndexBits-1:0]   selected_index_o,
  output logic                            found_o,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [gps_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gps_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import gps_pkg::*;

  // address, population count and extended compare widths
  localparam int unsigned AW = $clog2(POP_MAX);
  localparam int unsigned NW = $clog2(POP_MAX + 1);
  localparam int unsigned EW = (NW > IndexBits) ? ((NW > PopBits) ? NW : PopBits)
                                                : ((IndexBits > PopBits) ? IndexBits
                                                                          : PopBits);
  // prefix sum never overflows and also holds the scaled point
  localparam int unsigned PW = (FITNESS_BITS + AW + 1 > TotalBits) ? FITNESS_BITS + AW + 1
                                                                  : TotalBits;

  // fitness memory, one write and one registered read port
  logic [FITNESS_BITS-1:0] mem_q [POP_MAX];
  logic [FITNESS_BITS-1:0] rd_data_q;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           wr_addr;
  logic [FITNESS_BITS-1:0] wr_data;

  gps_state_e state_q, state_d;

  // configuration
  logic               mode_q;
  logic [PopBits-1:0] pop_q;

  // running total
  logic [TotalBits-1:0] total_q, total_d;

  // operands held for the command in flight
  logic [AW-1:0]           addr_a_q, addr_a_d;
  logic [AW-1:0]           addr_b_q, addr_b_d;
  logic [FITNESS_BITS-1:0] val_q, val_d;
  logic [DrawBits-1:0]     draw_q, draw_d;

  // shared index: clearing pass and roulette walk
  logic [AW-1:0] idx_q, idx_d;

  // roulette datapath
  logic [2*DrawBits-1:0] prod_lo_q, prod_lo_d;
  logic [TotalBits-1:0]  point_q, point_d;
  logic [PW-1:0]         prefix_q, prefix_d;
  logic [PW-1:0]         prefix_sum;

  // result registers
  logic                 done_q, done_d;
  logic [IndexBits-1:0] sel_q, sel_d;
  logic                 found_q, found_d;

  // decoded command fields
  logic [NW-1:0]           n_eff;
  logic [AW-1:0]           last_slot;
  logic [EW-1:0]           slot_ext;
  logic                    slot_ok;
  logic [AW-1:0]           pick_a;
  logic [AW-1:0]           pick_b;
  logic [FITNESS_BITS-1:0] new_val;
  logic [AW-1:0]           res_idx;
  logic [EW-1:0]           res_ext;

  function automatic logic [NW-1:0] eff_pop(input logic [PopBits-1:0] pop);
    logic [EW-1:0] p;
    p = EW'(pop);
    if (p < EW'(2)) begin
      return NW'(2);
    end else if (p > EW'(POP_MAX)) begin
      return NW'(POP_MAX);
    end
    return NW'(p);
  endfunction

  // picks beyond the population go to the last slot in use
  function automatic logic [AW-1:0] clamp_pick(input logic [IndexBits-1:0] pick,
                                               input logic [NW-1:0] n);
    logic [EW-1:0] p;
    logic [EW-1:0] nn;
    p  = EW'(pick);
    nn = EW'(n);
    if (p >= nn) begin
      return AW'(nn - EW'(1));
    end
    return AW'(p);
  endfunction

  assign n_eff     = eff_pop(pop_q);
  assign last_slot = AW'(n_eff - NW'(1));
  assign slot_ext  = EW'(slot_i);
  assign slot_ok   = (slot_ext < EW'(POP_MAX));
  assign pick_a    = clamp_pick(first_pick_i, n_eff);
  assign pick_b    = clamp_pick(second_pick_i, n_eff);
  assign new_val   = FITNESS_BITS'(fitness_value_i);

  // one wide add and compare per walk step
  assign prefix_sum = prefix_q + PW'(rd_data_q);

  // memory: clocked write, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    addr_a_d  = addr_a_q;
    addr_b_d  = addr_b_q;
    val_d     = val_q;
    draw_d    = draw_q;
    idx_d     = idx_q;
    prod_lo_d = prod_lo_q;
    point_d   = point_q;
    prefix_d  = prefix_q;
    done_d    = 1'b0;
    sel_d     = sel_q;
    found_d   = found_q;
    rd_addr   = idx_q;
    mem_we    = 1'b0;
    wr_addr   = addr_a_q;
    wr_data   = val_q;
    res_idx   = addr_b_q;
    res_ext   = EW'(res_idx);

    unique case (state_q)
      StClear: begin
        mem_we  = 1'b1;
        wr_addr = idx_q;
        wr_data = '0;
        idx_d   = idx_q + AW'(1);
        if (idx_q == AW'(POP_MAX - 1)) begin
          idx_d   = '0;
          state_d = StIdle;
        end
      end

      StIdle: begin
        rd_addr = (func_i == FuncLoad) ? AW'(slot_ext) : pick_a;
        if (start) begin
          addr_a_d = (func_i == FuncLoad) ? AW'(slot_ext) : pick_a;
          addr_b_d = pick_b;
          val_d    = new_val;
          draw_d   = roulette_draw_i;
          if (func_i == FuncLoad) begin
            if (slot_ok) begin
              state_d = StLoadUpd;
            end
          end else if (mode_q == ModeTournament) begin
            state_d = StTnB;
          end else if (total_q == '0) begin
            // nothing on the wheel
            done_d  = 1'b1;
            sel_d   = '0;
            found_d = 1'b0;
          end else begin
            state_d = StRwMul;
          end
        end
      end

      StLoadUpd: begin
        // old value is on the read port now
        mem_we  = 1'b1;
        wr_addr = addr_a_q;
        wr_data = val_q;
        total_d = total_q - TotalBits'(rd_data_q) + TotalBits'(val_q);
        state_d = StIdle;
      end

      StTnB: begin
        val_d   = rd_data_q;
        rd_addr = addr_b_q;
        state_d = StTnCmp;
      end

      StTnCmp: begin
        // second pick wins a tie
        res_idx = (val_q > rd_data_q) ? addr_a_q : addr_b_q;
        res_ext = EW'(res_idx);
        done_d  = 1'b1;
        sel_d   = res_ext[IndexBits-1:0];
        found_d = 1'b1;
        state_d = StIdle;
      end

      StRwMul: begin
        prod_lo_d = (2*DrawBits)'(draw_q) * (2*DrawBits)'(total_q[DrawBits-1:0]);
        state_d   = StRwAdd;
      end

      StRwAdd: begin
        point_d  = TotalBits'(TotalBits'(draw_q) * TotalBits'(total_q[TotalBits-1:DrawBits]))
                 + TotalBits'(prod_lo_q[2*DrawBits-1:DrawBits]);
        prefix_d = '0;
        idx_d    = '0;
        rd_addr  = '0;
        state_d  = StRwWalk;
      end

      StRwWalk: begin
        rd_addr = idx_q + AW'(1);
        if (PW'(point_q) < prefix_sum) begin
          res_idx = idx_q;
          res_ext = EW'(res_idx);
          done_d  = 1'b1;
          sel_d   = res_ext[IndexBits-1:0];
          found_d = 1'b1;
          state_d = StIdle;
        end else if (idx_q == last_slot) begin
          // walked the whole population without a hit
          done_d  = 1'b1;
          sel_d   = '0;
          found_d = 1'b0;
          state_d = StIdle;
        end else begin
          prefix_d = prefix_sum;
          idx_d    = idx_q + AW'(1);
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
      mode_q  <= ModeTournament;
      pop_q   <= PopBits'(64);
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegSelectionMode:  mode_q <= cfg_wdata_i[0];
          RegPopulationSize: pop_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    addr_a_q  <= addr_a_d;
    addr_b_q  <= addr_b_d;
    val_q     <= val_d;
    draw_q    <= draw_d;
    prod_lo_q <= prod_lo_d;
    point_q   <= point_d;
    prefix_q  <= prefix_d;
    sel_q     <= sel_d;
    found_q   <= found_d;
  end

  assign busy             = (state_q != StIdle);
  assign done_o           = done_q;
  assign selected_index_o = sel_q;
  assign found_o          = found_q;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ga parent selection block: a directed table
// of load and select words, then phases of random words under varied
// selection mode, population size and sender gaps, each select result
// checked against its typed expectation or a local model of the fitness table
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gps_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 4;
  // slowest word is a roulette walk over the whole table plus scaling
  localparam int unsigned SETTLE_WAIT  = PopMaxDef + 8;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_WORDS  = 50;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned REPORT_MAX   = 10;

  // one row of the stimulus table: either a register write or a command word
  typedef enum logic [1:0] {
    RowCfg,
    RowItem
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CfgIdxW-1:0]     reg_idx;
    logic [CfgDataW-1:0]    reg_val;
    logic                   func;
    logic [IndexBits-1:0]   slot;
    logic [ValueBits-1:0]   value;
    logic [IndexBits-1:0]   pick_a;
    logic [IndexBits-1:0]   pick_b;
    logic [DrawBits-1:0]    draw;
    logic                   fixed;      // expected result typed into the row
    logic [IndexBits-1:0]   exp_idx;
    logic                   exp_found;
  } stim_row_t;

  typedef struct packed {
    logic [IndexBits-1:0] idx;
    logic                 found;
  } parent_t;

  // dut signals
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  func_i;
  logic [IndexBits-1:0]  slot_i;
  logic [ValueBits-1:0]  fitness_value_i;
  logic [IndexBits-1:0]  first_pick_i;
  logic [IndexBits-1:0]  second_pick_i;
  logic [DrawBits-1:0]   roulette_draw_i;
  logic                  done_o;
  logic [IndexBits-1:0]  selected_index_o;
  logic                  found_o;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_wdata_i;

  // local copy of the block state and its registers
  logic [ValueBits-1:0]  fit_mem [PopMaxDef];
  logic [TotalBits-1:0]  fit_sum;
  logic                  sel_mode;
  logic [PopBits-1:0]    pop_reg;

  parent_t               parent_q [$];   // select results still to arrive
  stim_row_t             stim_tab [$];
  int unsigned           idle_pct;
  int unsigned           mismatch_cnt;
  int unsigned           cycle_cnt;

  ga_parent_selection_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .slot_i           (slot_i),
    .fitness_value_i  (fitness_value_i),
    .first_pick_i     (first_pick_i),
    .second_pick_i    (second_pick_i),
    .roulette_draw_i  (roulette_draw_i),
    .done_o           (done_o),
    .selected_index_o (selected_index_o),
    .found_o          (found_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // population register as the block uses it: below 2 acts as 2, above
  // the table depth acts as the depth
  function automatic int unsigned live_slots();
    if (pop_reg < 2) return 2;
    if (pop_reg > PopMaxDef) return PopMaxDef;
    return pop_reg;
  endfunction

  // parent chosen by a select word under the current mode and table
  function automatic parent_t pick_parent(input logic [IndexBits-1:0] raw_a,
                                          input logic [IndexBits-1:0] raw_b,
                                          input logic [DrawBits-1:0]  draw);
    int unsigned          n;
    logic [IndexBits-1:0] a;
    logic [IndexBits-1:0] b;
    logic [69:0]          prod;
    logic [TotalBits-1:0] point;
    logic [39:0]          run;
    parent_t              res;
    n   = live_slots();
    res = '0;
    if (sel_mode == ModeTournament) begin
      // picks past the population fall back to the last live slot
      a = (raw_a >= n) ? IndexBits'(n - 1) : raw_a;
      b = (raw_b >= n) ? IndexBits'(n - 1) : raw_b;
      // strictly greater, so a tie goes to the second pick
      res.idx   = (fit_mem[a] > fit_mem[b]) ? a : b;
      res.found = 1'b1;
    end else if (fit_sum != '0) begin
      // point = floor(draw * total / 2^32), truncated
      prod  = 70'(draw) * 70'(fit_sum);
      point = prod[69:32];
      run   = '0;
      // first live slot whose prefix sum passes the point; fitness parked
      // beyond the population is in the total but never walked
      for (int j = 0; j < n; j++) begin
        run += 40'(fit_mem[j]);
        if (!res.found && 40'(point) < run) begin
          res.idx   = IndexBits'(j);
          res.found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic flag(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
  endtask

  // table builders
  task automatic tab_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    stim_row_t r;
    r         = '{kind: RowCfg, default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    stim_tab  = {stim_tab, r};
  endtask

  task automatic tab_load(input logic [IndexBits-1:0] slot, input logic [ValueBits-1:0] val);
    stim_row_t r;
    r        = '{kind: RowItem, default: '0};
    r.func   = FuncLoad;
    r.slot   = slot;
    r.value  = val;
    stim_tab = {stim_tab, r};
  endtask

  task automatic tab_sel(input logic [IndexBits-1:0] a, input logic [IndexBits-1:0] b,
                         input logic [DrawBits-1:0] draw, input logic fixed,
                         input logic [IndexBits-1:0] idx, input logic found);
    stim_row_t r;
    r           = '{kind: RowItem, default: '0};
    r.func      = FuncSelect;
    r.pick_a    = a;
    r.pick_b    = b;
    r.draw      = draw;
    r.fixed     = fixed;
    r.exp_idx   = idx;
    r.exp_found = found;
    stim_tab    = {stim_tab, r};
  endtask

  // offer one command word, hold it until taken, then update the model
  task automatic send_word(input stim_row_t r);
    parent_t want;
    // random sender gap before the word
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    func_i          <= r.func;
    slot_i          <= r.slot;
    fitness_value_i <= r.value;
    first_pick_i    <= r.pick_a;
    second_pick_i   <= r.pick_b;
    roulette_draw_i <= r.draw;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // taken at this edge
    if (r.func == FuncSelect) begin
      want = pick_parent(r.pick_a, r.pick_b, r.draw);
      if (r.fixed) want = '{idx: r.exp_idx, found: r.exp_found};
      parent_q = {parent_q, want};
    end else begin
      fit_sum        = fit_sum - TotalBits'(fit_mem[r.slot]) + TotalBits'(r.value);
      fit_mem[r.slot] = r.value;
    end
  endtask

  // let the block run dry: all results in, then room for a trailing load
  task automatic settle();
    start <= 1'b0;
    while (parent_q.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == RegSelectionMode) sel_mode = val[0];
    else pop_reg = val;
  endtask

  // result side: every strobe must match the oldest outstanding select
  always @(posedge clk_i) begin : watch
    parent_t want;
    if (rst_ni && done_o) begin
      if (parent_q.size() == 0) begin
        flag($sformatf("result with nothing outstanding: idx %0d found %0b",
                       selected_index_o, found_o));
      end else begin
        want = parent_q.pop_front();
        if (selected_index_o !== want.idx || found_o !== want.found) begin
          flag($sformatf("result mismatch: idx exp %0d got %0d, found exp %0b got %0b",
                         want.idx, selected_index_o, want.found, found_o));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    stim_row_t   r;
    int unsigned n;
    logic        mode;
    logic [CfgDataW-1:0] pop_val;

    // every input known from time zero, reset held
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = FuncLoad;
    slot_i          = '0;
    fitness_value_i = '0;
    first_pick_i    = '0;
    second_pick_i   = '0;
    roulette_draw_i = '0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = RegSelectionMode;
    cfg_wdata_i     = '0;
    idle_pct        = 0;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    for (int i = 0; i < PopMaxDef; i++) fit_mem[i] = '0;
    fit_sum  = '0;
    sel_mode = ModeTournament;
    pop_reg  = PopBits'(PopMaxDef);

    // directed table
    // empty table after reset: every fitness ties, second pick wins
    tab_sel(6'd0,  6'd63, 32'h0, 1'b1, 6'd63, 1'b1);
    tab_sel(6'd63, 6'd0,  32'h0, 1'b1, 6'd0,  1'b1);
    tab_cfg(RegSelectionMode, CfgDataW'(ModeRoulette));
    // roulette with zero total: not found
    tab_sel(6'd0, 6'd0, 32'hffff_ffff, 1'b1, 6'd0, 1'b0);
    tab_load(6'd0,  32'hffff_ffff);
    tab_load(6'd63, 32'hffff_ffff);
    // zero draw lands on the first non-empty slot
    tab_sel(6'd0, 6'd0, 32'h0, 1'b1, 6'd0, 1'b1);
    tab_sel(6'd0, 6'd0, 32'hffff_ffff, 1'b0, '0, 1'b0);
    // overwrite a slot, total must drop back
    tab_load(6'd0, 32'h0);
    tab_sel(6'd0, 6'd0, 32'h0,         1'b0, '0, 1'b0);
    tab_sel(6'd0, 6'd0, 32'h8000_0000, 1'b0, '0, 1'b0);
    // only the slot beyond the population holds fitness: walk finds nothing
    tab_cfg(RegPopulationSize, 7'd2);
    tab_sel(6'd0, 6'd0, 32'h4000_0000, 1'b0, '0, 1'b0);
    // upper data bits ignored by the mode register
    tab_cfg(RegSelectionMode, 7'b111_1110);
    // population below range acts as two
    tab_cfg(RegPopulationSize, 7'd0);
    tab_load(6'd1, 32'd5);
    tab_sel(6'd63, 6'd0,  32'h0, 1'b0, '0, 1'b0);
    tab_sel(6'd0,  6'd40, 32'h0, 1'b0, '0, 1'b0);
    // population above range acts as the full table
    tab_cfg(RegPopulationSize, 7'd127);
    tab_sel(6'd63, 6'd1, 32'h0, 1'b0, '0, 1'b0);
    tab_load(6'd63, 32'h0);
    tab_sel(6'd63, 6'd1, 32'h0, 1'b0, '0, 1'b0);
    tab_cfg(RegPopulationSize, 7'd1);
    tab_cfg(RegSelectionMode, CfgDataW'(ModeRoulette));
    tab_load(6'd1, 32'h0000_8000);
    tab_sel(6'd0, 6'd0, 32'hffff_ffff, 1'b0, '0, 1'b0);
    tab_sel(6'd0, 6'd0, 32'h0,         1'b0, '0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the table, no gaps; the first words wait out the clearing pass
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == RowCfg) begin
        settle();
        cfg_write(stim_tab[i].reg_idx, stim_tab[i].reg_val);
      end else begin
        send_word(stim_tab[i]);
      end
    end

    // random phases, each under its own mode, population and gap rate
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = p[0];
      case (p)
        0:       pop_val = 7'd64;
        1:       pop_val = 7'd2;
        2:       pop_val = 7'd0;
        3:       pop_val = 7'd127;
        4:       pop_val = 7'd1;
        5:       pop_val = 7'd5;
        6:       pop_val = CfgDataW'($urandom_range(2, 64));
        7:       pop_val = CfgDataW'($urandom_range(65, 127));
        default: pop_val = CfgDataW'($urandom_range(0, 127));
      endcase
      settle();
      cfg_write(RegSelectionMode, {6'($urandom), mode});
      cfg_write(RegPopulationSize, pop_val);
      case (p % 4)
        1:       idle_pct = 62;
        3:       idle_pct = 27;
        default: idle_pct = 0;
      endcase
      n = live_slots();
      for (int k = 0; k < PHASE_WORDS; k++) begin
        r      = '{kind: RowItem, default: '0};
        r.func = ($urandom_range(0, 99) < 40) ? FuncLoad : FuncSelect;
        // loads mostly into live slots, some parked beyond the population
        r.slot = ($urandom_range(0, 99) < 85) ? IndexBits'($urandom_range(0, n - 1))
                                              : IndexBits'($urandom);
        case ($urandom_range(0, 9))
          0:       r.value = 32'h0;
          1:       r.value = 32'hffff_ffff;
          2, 3, 4: r.value = 32'($urandom_range(0, 1023));
          default: r.value = $urandom;
        endcase
        r.pick_a = ($urandom_range(0, 1) != 0) ? IndexBits'($urandom)
                                               : IndexBits'($urandom_range(0, n - 1));
        r.pick_b = ($urandom_range(0, 1) != 0) ? IndexBits'($urandom)
                                               : IndexBits'($urandom_range(0, n - 1));
        if ($urandom_range(0, 9) == 0) r.pick_b = r.pick_a;
        case ($urandom_range(0, 9))
          0:       r.draw = 32'h0;
          1:       r.draw = 32'hffff_ffff;
          default: r.draw = $urandom;
        endcase
        send_word(r);
      end
    end

    settle();
    if (mismatch_cnt == 0 && parent_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hdl/gps_pkg.sv
hdl/ga_parent_selection_top.sv
tb/tb_top.sv
